[rtl/core/xysm_pkg.sv]
package xysm_pkg;

  // default geometry and table size
  localparam int LatticeWidthDef  = 64;
  localparam int LatticeHeightDef = 64;
  localparam int CosTableDepthDef = 1024;

  // fixed field widths and store geometry
  localparam int SiteW      = 12;
  localparam int AngleW     = 16;
  localparam int EnergyW    = 16;
  localparam int TempW      = 16;
  localparam int StoreDepth = 4096;

  localparam logic [TempW-1:0]  TempReset = 16'd256;
  localparam logic [AngleW-1:0] HalfTurn  = 16'h8000;

  // quarter-wave cosine polynomial coefficients, Q30
  localparam logic [30:0] CosCoef [7] = '{
    31'd1073741824, 31'd1324675879, 31'd272375560, 31'd22401992,
    31'd987049, 31'd27060, 31'd506
  };

  // e^-n for the integer part, Q30
  localparam logic [30:0] ExpInt [12] = '{
    31'd1073741824, 31'd395007542, 31'd145315154, 31'd53458457,
    31'd19666267, 31'd7234815, 31'd2661540, 31'd979126,
    31'd360200, 31'd132510, 31'd48748, 31'd17933
  };

  // e^-(2^-j) for fraction bits j = 1..12, Q30
  localparam logic [30:0] ExpFrac [12] = '{
    31'd651257337, 31'd836230974, 31'd947573834, 31'd1008687096,
    31'd1040706261, 31'd1057095000, 31'd1065385899, 31'd1069555701,
    31'd1071646719, 31'd1072693760, 31'd1073217664, 31'd1073479712
  };

  // datapath operations
  localparam logic [4:0] OP_NONE    = 5'd0;
  localparam logic [4:0] OP_CLEAR   = 5'd1;
  localparam logic [4:0] OP_LOAD    = 5'd2;
  localparam logic [4:0] OP_ROW_MUL = 5'd3;
  localparam logic [4:0] OP_ROW_CHK = 5'd4;
  localparam logic [4:0] OP_ROW_FIX = 5'd5;
  localparam logic [4:0] OP_NB      = 5'd6;
  localparam logic [4:0] OP_RD      = 5'd7;
  localparam logic [4:0] OP_COS_IDX = 5'd8;
  localparam logic [4:0] OP_COS_QE  = 5'd9;
  localparam logic [4:0] OP_COS_CHK = 5'd10;
  localparam logic [4:0] OP_COS_FIX = 5'd11;
  localparam logic [4:0] OP_COS_SQ  = 5'd12;
  localparam logic [4:0] OP_COS_S   = 5'd13;
  localparam logic [4:0] OP_HMUL    = 5'd14;
  localparam logic [4:0] OP_HSUB    = 5'd15;
  localparam logic [4:0] OP_COS_ACC = 5'd16;
  localparam logic [4:0] OP_DE      = 5'd17;
  localparam logic [4:0] OP_EMUL    = 5'd18;
  localparam logic [4:0] OP_EK      = 5'd19;
  localparam logic [4:0] OP_XMUL    = 5'd20;
  localparam logic [4:0] OP_XRND    = 5'd21;
  localparam logic [4:0] OP_DEC     = 5'd22;
  localparam logic [4:0] OP_WR      = 5'd23;
  localparam logic [4:0] OP_OUT     = 5'd24;

  typedef struct packed {
    logic [SiteW-1:0]  site_index;
    logic [AngleW-1:0] proposal_offset;
    logic [15:0]       accept_draw;
  } in_item_t;

  typedef struct packed {
    logic [SiteW-1:0]          updated_site;
    logic                      accepted;
    logic [AngleW-1:0]         spin_angle;
    logic signed [EnergyW-1:0] energy_change;
  } out_item_t;

  typedef struct packed {
    logic [4:0] op;
    logic [3:0] idx;
    logic       cap_en;
    logic [2:0] cap_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic in_range;
    logic out_free;
  } dp_status_t;

endpackage

[rtl/core/xy_spin_metropolis_update_core.sv]
// one item at a time: no new input is taken until the result of the last one is in the
// output register; the work per item is set by the shared 32x32 multiplier doing
// eight cosine evaluations and twelve exp steps, which a site beyond the lattice skips
// after reset the spin store is swept to a half turn; no input is taken until the
// sweep ends, configuration writes are taken at any time
module xy_spin_metropolis_update_core #(
  parameter int LATTICE_WIDTH   = xysm_pkg::LatticeWidthDef,
  parameter int LATTICE_HEIGHT  = xysm_pkg::LatticeHeightDef,
  parameter int COS_TABLE_DEPTH = xysm_pkg::CosTableDepthDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  xysm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output xysm_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);

  xysm_pkg::dp_cmd_t    cmd;
  xysm_pkg::dp_status_t status;

  // config register always accepts
  assign cfg_ready = 1'b1;

  xysm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  xysm_datapath #(
    .LATTICE_WIDTH   (LATTICE_WIDTH),
    .LATTICE_HEIGHT  (LATTICE_HEIGHT),
    .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[rtl/core/xysm_ram.sv]
module xysm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/xysm_datapath.sv]
module xysm_datapath #(
  parameter int LATTICE_WIDTH   = xysm_pkg::LatticeWidthDef,
  parameter int LATTICE_HEIGHT  = xysm_pkg::LatticeHeightDef,
  parameter int COS_TABLE_DEPTH = xysm_pkg::CosTableDepthDef
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  xysm_pkg::dp_cmd_t       cmd,
  output xysm_pkg::dp_status_t    status,
  input  xysm_pkg::in_item_t      in_data,
  input  logic                    cfg_valid,
  input  logic [15:0]             cfg_data,
  input  logic                    out_ready,
  output logic                    out_valid,
  output xysm_pkg::out_item_t     out_data
);

  localparam int AddrW = $clog2(xysm_pkg::StoreDepth);
  localparam logic [20:0] NumSites = 21'(LATTICE_WIDTH * LATTICE_HEIGHT);
  localparam logic [31:0] RowRecip =
    32'(((64'd1 << 24) + 64'(LATTICE_WIDTH) - 64'd1) / 64'(LATTICE_WIDTH));
  localparam logic [31:0] CosRecip =
    32'(((64'd1 << 32) + 64'(COS_TABLE_DEPTH) - 64'd1) / 64'(COS_TABLE_DEPTH));
  localparam logic [11:0] Wd     = 12'(LATTICE_WIDTH);
  localparam logic [11:0] WdM1   = 12'(LATTICE_WIDTH - 1);
  localparam logic [11:0] Ht     = 12'(LATTICE_HEIGHT);
  localparam logic [11:0] LastRowBase = 12'((LATTICE_HEIGHT - 1) * LATTICE_WIDTH);

  xysm_pkg::in_item_t  in_r;
  xysm_pkg::out_item_t out_r;
  logic                out_valid_r;
  logic [15:0]         inv_temp_r;
  logic [12:0]         clr_r;

  logic [11:0]  yy_r, yw_r;
  logic [11:0]  nb_r [4];
  logic [15:0]  old_r;
  logic [15:0]  nbv_r [4];
  logic [63:0]  mul_r;
  logic [16:0]  idx_r, qe_r;
  logic [1:0]   quad_r;
  logic [14:0]  t_r;
  logic [28:0]  s_r;
  logic [30:0]  acc_r;
  logic signed [18:0] sum_r;
  logic signed [15:0] de_r;
  logic [22:0]  k_r;
  logic         acc_flag_r;

  logic [31:0]  mul_a, mul_b;
  logic [15:0]  newv, ang, dif;
  logic [11:0]  xx, xp, xm;
  logic [16:0]  pq;
  logic [15:0]  p16;
  logic [30:0]  prod_h, rnd;
  logic [14:0]  cval;
  logic signed [16:0] sq;
  logic [16:0]  prob;
  logic         in_range, de_nonpos;
  logic         ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [15:0]  ram_wdata, ram_rdata;

  // combinational helpers
  assign newv      = old_r + in_r.proposal_offset;
  assign ang       = cmd.idx[0] ? newv : old_r;
  assign dif       = ang - nbv_r[cmd.idx[2:1]];
  assign in_range  = 21'(in_r.site_index) < NumSites;
  assign xx        = in_r.site_index - yw_r;
  assign xp        = (xx + 12'd1 == Wd) ? 12'd0 : xx + 12'd1;
  assign xm        = (xx == 12'd0) ? WdM1 : xx - 12'd1;
  assign pq        = (mul_r > {31'd0, idx_r, 16'd0}) ? qe_r - 17'd1 : qe_r;
  assign p16       = pq[15:0];
  assign prod_h    = mul_r[58:28];
  assign rnd       = 31'((mul_r + 64'd536870912) >> 30);
  assign cval      = 15'(({1'b0, acc_r} + 32'd32768) >> 16);
  assign sq        = 17'(sum_r >>> 2);
  assign prob      = 17'(({1'b0, acc_r} + 32'd8192) >> 14);
  assign de_nonpos = de_r[15] || (de_r == 16'sd0);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      xysm_pkg::OP_ROW_MUL: begin
        mul_a = 32'(in_r.site_index);
        mul_b = RowRecip;
      end
      xysm_pkg::OP_ROW_CHK: begin
        mul_a = 32'(mul_r[35:24]);
        mul_b = 32'(Wd);
      end
      xysm_pkg::OP_COS_IDX: begin
        mul_a = 32'(dif);
        mul_b = 32'(COS_TABLE_DEPTH);
      end
      xysm_pkg::OP_COS_QE: begin
        mul_a = 32'(mul_r[32:16]);
        mul_b = CosRecip;
      end
      xysm_pkg::OP_COS_CHK: begin
        mul_a = 32'(mul_r[32:16]);
        mul_b = 32'(COS_TABLE_DEPTH);
      end
      xysm_pkg::OP_COS_SQ: begin
        mul_a = 32'(t_r);
        mul_b = 32'(t_r);
      end
      xysm_pkg::OP_HMUL: begin
        mul_a = 32'(acc_r);
        mul_b = 32'(s_r);
      end
      xysm_pkg::OP_EMUL: begin
        mul_a = 32'(de_r[14:0]);
        mul_b = 32'(inv_temp_r);
      end
      xysm_pkg::OP_XMUL: begin
        mul_a = 32'(acc_r);
        mul_b = 32'(xysm_pkg::ExpFrac[cmd.idx]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // spin store port select
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = in_r.site_index;
    ram_wdata = newv;
    case (cmd.op)
      xysm_pkg::OP_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_r[AddrW-1:0];
        ram_wdata = xysm_pkg::HalfTurn;
      end
      xysm_pkg::OP_RD: begin
        if (cmd.idx != 4'd0) begin
          ram_addr = nb_r[cmd.idx[1:0] - 2'd1];
        end
      end
      xysm_pkg::OP_WR: begin
        ram_we = acc_flag_r;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  xysm_ram #(
    .WIDTH (xysm_pkg::AngleW),
    .DEPTH (xysm_pkg::StoreDepth)
  ) u_spin_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // control registers: clear sweep, config, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      inv_temp_r  <= xysm_pkg::TempReset;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == xysm_pkg::OP_CLEAR) begin
        clr_r <= clr_r + 13'd1;
      end
      if (cfg_valid) begin
        inv_temp_r <= cfg_data;
      end
      if (cmd.op == xysm_pkg::OP_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    mul_r <= 64'(mul_a) * 64'(mul_b);
    if (cmd.cap_en) begin
      if (cmd.cap_idx == 3'd0) begin
        old_r <= ram_rdata;
      end else begin
        nbv_r[cmd.cap_idx[1:0] - 2'd1] <= ram_rdata;
      end
    end
    case (cmd.op)
      xysm_pkg::OP_LOAD: begin
        in_r <= in_data;
      end
      xysm_pkg::OP_ROW_CHK: begin
        yy_r <= mul_r[35:24];
      end
      xysm_pkg::OP_ROW_FIX: begin
        if (mul_r > 64'(in_r.site_index)) begin
          yy_r <= yy_r - 12'd1;
          yw_r <= mul_r[11:0] - Wd;
        end else begin
          yw_r <= mul_r[11:0];
        end
      end
      xysm_pkg::OP_NB: begin
        nb_r[0] <= xx + ((yy_r + 12'd1 == Ht) ? 12'd0 : yw_r + Wd);
        nb_r[1] <= xp + yw_r;
        nb_r[2] <= xx + ((yy_r == 12'd0) ? LastRowBase : yw_r - Wd);
        nb_r[3] <= xm + yw_r;
        sum_r   <= '0;
      end
      xysm_pkg::OP_COS_QE: begin
        idx_r <= mul_r[32:16];
      end
      xysm_pkg::OP_COS_CHK: begin
        qe_r <= mul_r[32:16];
      end
      xysm_pkg::OP_COS_FIX: begin
        quad_r <= p16[15:14];
        t_r    <= p16[14] ? 15'd16384 - {1'b0, p16[13:0]} : {1'b0, p16[13:0]};
      end
      xysm_pkg::OP_COS_S: begin
        s_r   <= mul_r[28:0];
        acc_r <= xysm_pkg::CosCoef[6];
      end
      xysm_pkg::OP_HSUB: begin
        acc_r <= (xysm_pkg::CosCoef[cmd.idx[2:0]] > prod_h) ?
                 xysm_pkg::CosCoef[cmd.idx[2:0]] - prod_h : 31'd0;
      end
      xysm_pkg::OP_COS_ACC: begin
        // old-angle terms add the cosine, new-angle terms subtract it
        if ((quad_r == 2'd1 || quad_r == 2'd2) ^ cmd.idx[0]) begin
          sum_r <= sum_r - 19'(cval);
        end else begin
          sum_r <= sum_r + 19'(cval);
        end
      end
      xysm_pkg::OP_DE: begin
        de_r <= (sq > 17'sd32767) ? 16'sd32767 : sq[15:0];
      end
      xysm_pkg::OP_EK: begin
        k_r <= mul_r[30:8];
        // large exponent gives zero probability
        if (mul_r[30:20] >= 11'd12) begin
          acc_r <= '0;
        end else begin
          acc_r <= xysm_pkg::ExpInt[mul_r[23:20]];
        end
      end
      xysm_pkg::OP_XRND: begin
        if (k_r[4'd11 - cmd.idx]) begin
          acc_r <= rnd;
        end
      end
      xysm_pkg::OP_DEC: begin
        acc_flag_r <= de_nonpos || (in_r.accept_draw < prob[15:0]) || prob[16];
      end
      xysm_pkg::OP_OUT: begin
        out_r.updated_site <= in_r.site_index;
        if (in_range) begin
          out_r.accepted      <= acc_flag_r;
          out_r.spin_angle    <= acc_flag_r ? newv : old_r;
          out_r.energy_change <= de_r;
        end else begin
          out_r.accepted      <= 1'b0;
          out_r.spin_angle    <= '0;
          out_r.energy_change <= '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign status.clear_done = clr_r[12];
  assign status.in_range   = in_range;
  assign status.out_free   = !out_valid_r || out_ready;
  assign out_valid         = out_valid_r;
  assign out_data          = out_r;

endmodule

[rtl/core/xysm_ctrl.sv]
module xysm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  xysm_pkg::dp_status_t status,
  output xysm_pkg::dp_cmd_t    cmd
);

  localparam logic [4:0] S_CLEAR = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_ROW0  = 5'd2;
  localparam logic [4:0] S_ROW1  = 5'd3;
  localparam logic [4:0] S_ROW2  = 5'd4;
  localparam logic [4:0] S_NB    = 5'd5;
  localparam logic [4:0] S_RD    = 5'd6;
  localparam logic [4:0] S_CIDX  = 5'd7;
  localparam logic [4:0] S_CQE   = 5'd8;
  localparam logic [4:0] S_CCHK  = 5'd9;
  localparam logic [4:0] S_CFIX  = 5'd10;
  localparam logic [4:0] S_CSQ   = 5'd11;
  localparam logic [4:0] S_CS    = 5'd12;
  localparam logic [4:0] S_HMUL  = 5'd13;
  localparam logic [4:0] S_HSUB  = 5'd14;
  localparam logic [4:0] S_CACC  = 5'd15;
  localparam logic [4:0] S_DE    = 5'd16;
  localparam logic [4:0] S_EMUL  = 5'd17;
  localparam logic [4:0] S_EK    = 5'd18;
  localparam logic [4:0] S_XMUL  = 5'd19;
  localparam logic [4:0] S_XRND  = 5'd20;
  localparam logic [4:0] S_DEC   = 5'd21;
  localparam logic [4:0] S_WR    = 5'd22;
  localparam logic [4:0] S_DONE  = 5'd23;

  logic [4:0] state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic [2:0] term_r, term_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cnt_r   <= '0;
      term_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      term_r  <= term_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    term_nxt  = term_r;
    cmd       = '0;
    cmd.op    = xysm_pkg::OP_NONE;
    unique case (state_r)
      S_CLEAR: begin
        if (status.clear_done) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.op = xysm_pkg::OP_CLEAR;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = xysm_pkg::OP_LOAD;
          state_nxt = S_ROW0;
        end
      end
      S_ROW0: begin
        cmd.op    = xysm_pkg::OP_ROW_MUL;
        state_nxt = S_ROW1;
      end
      S_ROW1: begin
        cmd.op    = xysm_pkg::OP_ROW_CHK;
        state_nxt = S_ROW2;
      end
      S_ROW2: begin
        cmd.op    = xysm_pkg::OP_ROW_FIX;
        state_nxt = status.in_range ? S_NB : S_DONE;
      end
      S_NB: begin
        cmd.op    = xysm_pkg::OP_NB;
        cnt_nxt   = '0;
        state_nxt = S_RD;
      end
      S_RD: begin
        // issue site then four neighbour reads, capture each read in the next cycle
        cmd.op      = xysm_pkg::OP_RD;
        cmd.idx     = cnt_r;
        cmd.cap_en  = (cnt_r != 4'd0);
        cmd.cap_idx = 3'(cnt_r - 4'd1);
        if (cnt_r == 4'd5) begin
          term_nxt  = '0;
          state_nxt = S_CIDX;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      S_CIDX: begin
        cmd.op    = xysm_pkg::OP_COS_IDX;
        cmd.idx   = {1'b0, term_r};
        state_nxt = S_CQE;
      end
      S_CQE: begin
        cmd.op    = xysm_pkg::OP_COS_QE;
        state_nxt = S_CCHK;
      end
      S_CCHK: begin
        cmd.op    = xysm_pkg::OP_COS_CHK;
        state_nxt = S_CFIX;
      end
      S_CFIX: begin
        cmd.op    = xysm_pkg::OP_COS_FIX;
        state_nxt = S_CSQ;
      end
      S_CSQ: begin
        cmd.op    = xysm_pkg::OP_COS_SQ;
        state_nxt = S_CS;
      end
      S_CS: begin
        cmd.op    = xysm_pkg::OP_COS_S;
        cnt_nxt   = 4'd5;
        state_nxt = S_HMUL;
      end
      S_HMUL: begin
        cmd.op    = xysm_pkg::OP_HMUL;
        state_nxt = S_HSUB;
      end
      S_HSUB: begin
        cmd.op  = xysm_pkg::OP_HSUB;
        cmd.idx = cnt_r;
        if (cnt_r == 4'd0) begin
          state_nxt = S_CACC;
        end else begin
          cnt_nxt   = cnt_r - 4'd1;
          state_nxt = S_HMUL;
        end
      end
      S_CACC: begin
        cmd.op  = xysm_pkg::OP_COS_ACC;
        cmd.idx = {1'b0, term_r};
        if (term_r == 3'd7) begin
          state_nxt = S_DE;
        end else begin
          term_nxt  = term_r + 3'd1;
          state_nxt = S_CIDX;
        end
      end
      S_DE: begin
        cmd.op    = xysm_pkg::OP_DE;
        state_nxt = S_EMUL;
      end
      S_EMUL: begin
        cmd.op    = xysm_pkg::OP_EMUL;
        state_nxt = S_EK;
      end
      S_EK: begin
        cmd.op    = xysm_pkg::OP_EK;
        cnt_nxt   = '0;
        state_nxt = S_XMUL;
      end
      S_XMUL: begin
        cmd.op    = xysm_pkg::OP_XMUL;
        cmd.idx   = cnt_r;
        state_nxt = S_XRND;
      end
      S_XRND: begin
        cmd.op  = xysm_pkg::OP_XRND;
        cmd.idx = cnt_r;
        if (cnt_r == 4'd11) begin
          state_nxt = S_DEC;
        end else begin
          cnt_nxt   = cnt_r + 4'd1;
          state_nxt = S_XMUL;
        end
      end
      S_DEC: begin
        cmd.op    = xysm_pkg::OP_DEC;
        state_nxt = S_WR;
      end
      S_WR: begin
        cmd.op    = xysm_pkg::OP_WR;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.op    = xysm_pkg::OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

[sim/xy_spin_metropolis_update_checker.sv]
`timescale 1ns / 1ps

module xy_spin_metropolis_update_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  xysm_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  xysm_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [15:0]         cfg_data,
  output int                  fail_count,
  output int                  pending_count
);

  localparam int LatW = xysm_pkg::LatticeWidthDef;
  localparam int LatH = xysm_pkg::LatticeHeightDef;
  localparam int CosDepth = xysm_pkg::CosTableDepthDef;

  logic [xysm_pkg::AngleW-1:0] spin_mirror [xysm_pkg::StoreDepth];
  logic [xysm_pkg::TempW-1:0]  inv_temp;
  xysm_pkg::out_item_t         expected_updates [$];

  // cos(pi/2 * t), Q1.14, t in Q0.14
  function automatic longint quarter_wave_cos(longint t);
    longint sq, acc, prod;
    sq = t * t;
    acc = xysm_pkg::CosCoef[6];
    for (int k = 5; k >= 0; k--) begin
      prod = (acc * sq) >>> 28;
      acc = (longint'(xysm_pkg::CosCoef[k]) > prod) ?
            longint'(xysm_pkg::CosCoef[k]) - prod : 0;
    end
    return (acc + 32768) >>> 16;
  endfunction

  function automatic longint table_cos(logic [15:0] diff);
    longint idx, ph, rem;
    idx = (longint'(diff) * CosDepth) >>> 16;
    ph = ((idx << 16) / CosDepth) & 16'hFFFF;
    rem = ph & 16'h3FFF;
    case (ph >> 14)
      0: return quarter_wave_cos(rem);
      1: return -quarter_wave_cos(16384 - rem);
      2: return -quarter_wave_cos(rem);
      default: return quarter_wave_cos(16384 - rem);
    endcase
  endfunction

  // acceptance threshold exp(-x), Q0.16
  function automatic longint boltzmann_q16(longint x);
    longint kq, acc;
    kq = x >>> 8;
    if ((kq >>> 12) >= 12) return 0;
    acc = xysm_pkg::ExpInt[kq >>> 12];
    for (int j = 1; j <= 12; j++)
      if ((kq >>> (12 - j)) & 1)
        acc = (acc * longint'(xysm_pkg::ExpFrac[j-1]) + 536870912) >>> 30;
    return (acc + 8192) >>> 14;
  endfunction

  function automatic xysm_pkg::out_item_t metropolis_update(xysm_pkg::in_item_t it);
    xysm_pkg::out_item_t r;
    int col, row, nb [4];
    logic [15:0] old_a, new_a;
    longint sum, de;
    logic acc;
    r = '0;
    r.updated_site = it.site_index;
    if (it.site_index >= LatW * LatH) return r;
    col = it.site_index % LatW;
    row = it.site_index / LatW;
    nb[0] = col + ((row + 1) % LatH) * LatW;
    nb[1] = (col + 1) % LatW + row * LatW;
    nb[2] = col + ((row + LatH - 1) % LatH) * LatW;
    nb[3] = (col + LatW - 1) % LatW + row * LatW;
    old_a = spin_mirror[it.site_index % xysm_pkg::StoreDepth];
    new_a = old_a + it.proposal_offset;
    sum = 0;
    for (int k = 0; k < 4; k++)
      sum += table_cos(old_a - spin_mirror[nb[k] % xysm_pkg::StoreDepth])
           - table_cos(new_a - spin_mirror[nb[k] % xysm_pkg::StoreDepth]);
    de = ((sum + 131072) >>> 2) - 32768;
    if (de > 32767) de = 32767;
    acc = (de <= 0) ? 1'b1 : (longint'(it.accept_draw) < boltzmann_q16(de * inv_temp));
    if (acc) spin_mirror[it.site_index % xysm_pkg::StoreDepth] = new_a;
    r.accepted = acc;
    r.spin_angle = acc ? new_a : old_a;
    r.energy_change = de[15:0];
    return r;
  endfunction

  assign pending_count = expected_updates.size();

  // track register, predict on input transfer, compare on output transfer
  always @(posedge clk) begin
    xysm_pkg::out_item_t exp_r;
    if (!rst_n) begin
      for (int i = 0; i < xysm_pkg::StoreDepth; i++) spin_mirror[i] = xysm_pkg::HalfTurn;
      inv_temp = xysm_pkg::TempReset;
      expected_updates.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) inv_temp = cfg_data;
      if (in_valid && in_ready) expected_updates.push_back(metropolis_update(in_data));
      if (out_valid && out_ready) begin
        if (expected_updates.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result %h", $time, out_data);
        end else begin
          exp_r = expected_updates.pop_front();
          if (exp_r.updated_site !== out_data.updated_site ||
              exp_r.accepted !== out_data.accepted ||
              exp_r.spin_angle !== out_data.spin_angle ||
              exp_r.energy_change !== out_data.energy_change) begin
            fail_count++;
            $display("%0t: mismatch expected site %0d acc %0d angle %h de %h, got %0d %0d %h %h",
                     $time, exp_r.updated_site, exp_r.accepted, exp_r.spin_angle,
                     exp_r.energy_change, out_data.updated_site, out_data.accepted,
                     out_data.spin_angle, out_data.energy_change);
          end
        end
      end
    end
  end
endmodule

[sim/xy_spin_metropolis_update_core_test.sv]
`timescale 1ns / 1ps

module xy_spin_metropolis_update_core_test;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0, out_ready = 1'b0, cfg_valid = 1'b0;
  logic      in_ready, out_valid, cfg_ready;
  xysm_pkg::in_item_t  in_data = '0;
  xysm_pkg::out_item_t out_data;
  logic [15:0] cfg_data = '0;
  int        fail_count, pending_count;
  logic      hold_off = 1'b0;

  xy_spin_metropolis_update_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  xy_spin_metropolis_update_checker u_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 400);
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
  endfunction

  // receiver backpressure, with phases of no stalls and one long hold-off
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (2000) @(posedge clk);
        hold_off = 1'b0;
      end
      n = ($urandom_range(0, 3) == 0) ? 0 : gap_len();
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  // valid stays high after a transfer until the next call drops it or reloads it
  task automatic send_update(logic [11:0] site, logic [15:0] offs, logic [15:0] draw,
                             bit no_gap);
    int n;
    n = no_gap ? 0 : gap_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{site_index: site, proposal_offset: offs, accept_draw: draw};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_then_set_temp(logic [15:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // mostly stay on a small patch so neighbours differ and both accept and reject occur
  task automatic random_sweep(int count);
    logic [11:0] site;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0: site = $urandom_range(0, 4095);
        1: site = {6'($urandom_range(0, 1) ? 0 : 63), 6'($urandom_range(0, 63))};
        default: site = {6'($urandom_range(0, 3)), 6'($urandom_range(0, 3))};
      endcase
      send_update(site, $urandom, $urandom, $urandom_range(0, 4) == 0);
    end
  endtask

  initial begin
    logic [11:0] corners [6];
    corners = '{12'd0, 12'd63, 12'd4032, 12'd4095, 12'd65, 12'd2080};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: lattice corners, edges and interior sites, offset and draw extremes, temperature extremes
    foreach (corners[i]) send_update(corners[i], 16'h0000, 16'h0000, 0);
    foreach (corners[i]) send_update(corners[i], 16'h8000, 16'hFFFF, 0);
    send_update(12'd1, 16'hFFFF, 16'hFFFF, 0);
    send_update(12'd64, 16'h4000, 16'h0001, 0);
    send_update(12'd0, 16'hC000, 16'hFFFF, 0);
    send_update(12'd1, 16'h2000, 16'h8000, 0);
    send_update(12'd127, 16'h5555, 16'hAAAA, 0);
    drain_then_set_temp(16'd0);
    send_update(12'd0, 16'h8000, 16'hFFFF, 0);
    send_update(12'd64, 16'h7FFF, 16'hFFFF, 0);
    drain_then_set_temp(16'hFFFF);
    send_update(12'd0, 16'h8000, 16'h0000, 0);
    send_update(12'd1, 16'h3000, 16'h0000, 0);

    // random phases across temperatures
    drain_then_set_temp(16'd256);
    random_sweep(300);
    hold_off = 1'b1;
    random_sweep(100);
    drain_then_set_temp(16'd64);
    random_sweep(300);
    drain_then_set_temp(16'd0);
    random_sweep(150);
    drain_then_set_temp(16'($urandom_range(1, 65535)));
    random_sweep(300);
    drain_then_set_temp(16'd2048);
    random_sweep(300);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #50_000_000;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
